// ===== hdl/alf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the additive lagged-Fibonacci generator.
// No dependencies.
package alf_pkg;

    localparam int WORD_W        = 32;
    localparam int RAND_W        = WORD_W - 1;
    localparam int RING_DEPTH    = 32;
    localparam int DISCARD_STEPS = 310;

    localparam int TAP_A     = 1;
    localparam int TAP_B     = RING_DEPTH - 3;
    localparam int CHAIN_LEN = RING_DEPTH - 1;
    localparam int IDX_W     = $clog2(RING_DEPTH);
    localparam int DISC_W    = (DISCARD_STEPS < 2) ? 1 : $clog2(DISCARD_STEPS);

    localparam int PROD_W = 31;
    localparam int MUL_W  = 15;
    localparam int HALF_W = 16;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [RAND_W-1:0] t_rand;

    localparam t_word            LCG_MOD = 32'h7fff_ffff;
    localparam logic [MUL_W-1:0] LCG_MUL = 15'd16807;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

endpackage

// ===== hdl/alf_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the generator's request and result items.
// Depends on alf_pkg.
interface alf_in_if;
    logic                valid;
    logic                ready;
    logic                opcode;
    alf_pkg::t_word      seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface alf_out_if;
    logic                valid;
    logic                ready;
    alf_pkg::t_rand      random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ===== hdl/alf_cell.sv =====
`timescale 1ns / 1ps
// One ring cell: holds a 32-bit word and loads its neighbor's word on shift.
// Depends on alf_pkg.
module alf_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  alf_pkg::t_word i_word,
    output alf_pkg::t_word o_word
);

    alf_pkg::t_word r_word;
    alf_pkg::t_word n_word;

    always_comb begin
        n_word = i_shift ? i_word : r_word;
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== hdl/alf_chain.sv =====
`timescale 1ns / 1ps
// Seed chain step: w' = 16807 * w mod (2^31 - 1), signed first word.
// Two stages: split multiply registered, then fold and reduce. Depends on alf_pkg.
module alf_chain (
    input  logic           i_clk,
    input  alf_pkg::t_word i_word,
    output alf_pkg::t_word o_word
);

    logic                         r_neg;
    logic [alf_pkg::PROD_W-1:0]   r_lo;
    logic [alf_pkg::PROD_W-1:0]   r_hi;
    alf_pkg::t_word               w_mag;
    logic [alf_pkg::PROD_W-1:0]   n_lo;
    logic [alf_pkg::PROD_W-1:0]   n_hi;
    logic [alf_pkg::WORD_W:0]     w_sum;
    logic [alf_pkg::WORD_W:0]     w_red;
    alf_pkg::t_word               w_t;

    always_comb begin
        w_mag = i_word[alf_pkg::WORD_W-1] ? (32'd0 - i_word) : i_word;
        n_lo  = alf_pkg::PROD_W'(alf_pkg::PROD_W'(alf_pkg::LCG_MUL)
                * alf_pkg::PROD_W'(w_mag[alf_pkg::HALF_W-1:0]));
        n_hi  = alf_pkg::PROD_W'(alf_pkg::PROD_W'(alf_pkg::LCG_MUL)
                * alf_pkg::PROD_W'(w_mag[alf_pkg::WORD_W-1:alf_pkg::HALF_W]));
    end

    always_ff @(posedge i_clk) begin
        r_neg <= i_word[alf_pkg::WORD_W-1];
        r_lo  <= n_lo;
        r_hi  <= n_hi;
    end

    always_comb begin
        w_sum = 33'(r_lo) + {2'b00, r_hi[14:0], 16'd0} + 33'(r_hi[30:15]);
        w_red = (w_sum >= 33'(alf_pkg::LCG_MOD)) ? (w_sum - 33'(alf_pkg::LCG_MOD)) : w_sum;
        w_t   = w_red[alf_pkg::WORD_W-1:0];
        o_word = (r_neg && (w_t != 32'd0)) ? (alf_pkg::LCG_MOD - w_t) : w_t;
    end

endmodule

// ===== hdl/additive_lagged_fibonacci_rng_unit.sv =====
`timescale 1ns / 1ps
// Additive lagged-Fibonacci generator top level; depends on alf_pkg, alf_ifs,
// alf_cell and alf_chain.
// The 32-word ring is a row of cells that shifts by one word per draw, the new
// word being the sum of two fixed taps, so draws stream at one item per cycle
// while results are taken. A reseed loads the seed word, runs 30 steps of the
// multiply-modulo seed chain, each a multiply then a reduce state, rotates in
// the first three words once more, then discards 310 draws. The first draw
// after reset seeds with 1 the same way and then gives its result from the
// draw state once the output is free. No input item is taken while a reseed runs.
module additive_lagged_fibonacci_rng_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alf_in_if.sink    i_in,
    alf_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RED,
        S_FILL,
        S_DISCARD,
        S_DRAW
    } t_state;

    localparam logic [1:0] FILL_W0 = 2'd0;
    localparam logic [1:0] FILL_W1 = 2'd1;
    localparam logic [1:0] FILL_W2 = 2'd2;

    t_state                          r_state, n_state;
    logic [alf_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [1:0]                      r_fill, n_fill;
    logic [alf_pkg::DISC_W-1:0]      r_disc, n_disc;
    logic                            r_seeded, n_seeded;
    logic                            r_pend, n_pend;
    alf_pkg::t_word                  r_prev, n_prev;
    alf_pkg::t_word                  r_w0, n_w0;
    alf_pkg::t_word                  r_w1, n_w1;
    alf_pkg::t_word                  r_w2, n_w2;
    logic                            r_out_valid, n_out_valid;
    alf_pkg::t_rand                  r_out_data, n_out_data;

    alf_pkg::t_word                  w_cell [alf_pkg::RING_DEPTH];
    alf_pkg::t_word                  w_feed;
    alf_pkg::t_word                  w_ins;
    alf_pkg::t_word                  w_seed;
    alf_pkg::t_word                  w_chain;
    logic                            w_shift;
    logic                            w_in_acc;
    logic                            w_out_free;

    for (genvar k = 0; k < alf_pkg::RING_DEPTH; k++) begin : g_cell
        if (k == alf_pkg::RING_DEPTH - 1) begin : g_tail
            alf_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_word (w_ins),
                .o_word (w_cell[k])
            );
        end else begin : g_body
            alf_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_word (w_cell[k+1]),
                .o_word (w_cell[k])
            );
        end
    end

    alf_chain u_chain (
        .i_clk (i_clk),
        .i_word(r_prev),
        .o_word(w_chain)
    );

    assign w_feed     = w_cell[alf_pkg::TAP_A] + w_cell[alf_pkg::TAP_B];
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.random_value = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_disc      = r_disc;
        n_seeded    = r_seeded;
        n_pend      = r_pend;
        n_prev      = r_prev;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_data  = r_out_data;
        w_shift     = 1'b0;
        w_ins       = w_feed;
        w_seed      = (i_in.opcode == alf_pkg::OP_SEED) ? i_in.seed_value : 32'd1;
        if (w_seed == 32'd0) begin
            w_seed = 32'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.opcode == alf_pkg::OP_SEED || !r_seeded) begin
                        w_shift  = 1'b1;
                        w_ins    = w_seed;
                        n_w0     = w_seed;
                        n_prev   = w_seed;
                        n_idx    = alf_pkg::IDX_W'(1);
                        n_seeded = 1'b1;
                        n_pend   = (i_in.opcode == alf_pkg::OP_DRAW);
                        n_state  = S_MUL;
                    end else begin
                        w_shift     = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_data  = w_feed[alf_pkg::WORD_W-1:1];
                    end
                end
            end
            S_MUL: begin
                n_state = S_RED;
            end
            S_RED: begin
                w_shift = 1'b1;
                w_ins   = w_chain;
                n_prev  = w_chain;
                if (r_idx == alf_pkg::IDX_W'(1)) begin
                    n_w1 = w_chain;
                end
                if (r_idx == alf_pkg::IDX_W'(2)) begin
                    n_w2 = w_chain;
                end
                if (r_idx == alf_pkg::IDX_W'(alf_pkg::CHAIN_LEN - 1)) begin
                    n_fill  = FILL_W0;
                    n_state = S_FILL;
                end else begin
                    n_idx   = r_idx + alf_pkg::IDX_W'(1);
                    n_state = S_MUL;
                end
            end
            S_FILL: begin
                w_shift = 1'b1;
                case (r_fill)
                    FILL_W0: w_ins = r_w0;
                    FILL_W1: w_ins = r_w1;
                    default: w_ins = r_w2;
                endcase
                if (r_fill == FILL_W2) begin
                    n_disc = '0;
                    if (alf_pkg::DISCARD_STEPS == 0) begin
                        n_state = r_pend ? S_DRAW : S_IDLE;
                    end else begin
                        n_state = S_DISCARD;
                    end
                end else begin
                    n_fill = r_fill + 2'd1;
                end
            end
            S_DISCARD: begin
                w_shift = 1'b1;
                if (r_disc == alf_pkg::DISC_W'(alf_pkg::DISCARD_STEPS - 1)) begin
                    n_state = r_pend ? S_DRAW : S_IDLE;
                end else begin
                    n_disc = r_disc + alf_pkg::DISC_W'(1);
                end
            end
            S_DRAW: begin
                if (w_out_free) begin
                    w_shift     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = w_feed[alf_pkg::WORD_W-1:1];
                    n_pend      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_fill      <= FILL_W0;
            r_disc      <= '0;
            r_seeded    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_fill      <= n_fill;
            r_disc      <= n_disc;
            r_seeded    <= n_seeded;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_prev     <= n_prev;
        r_w0       <= n_w0;
        r_w1       <= n_w1;
        r_w2       <= n_w2;
        r_out_data <= n_out_data;
    end

    a_seed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.opcode == alf_pkg::OP_SEED || !r_seeded))
        |=> (r_state == S_MUL) && r_seeded)
        else $error("seed item did not start the seed chain");

    a_chain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED) |-> (w_chain < alf_pkg::LCG_MOD))
        else $error("seed chain word out of range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_DRAW))
        else $error("result item raised during seeding");

    a_draw_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW) |-> r_pend && r_seeded)
        else $error("pending draw state without a pending draw");

endmodule
